/* rtl/core/pwpm_pkg.sv */
// ----------------------------------------------------------------------------
// pwpm_pkg: shared types and constants of the peak window matcher
// Operation codes, status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package pwpm_pkg;

  localparam int unsigned MassW      = 40;
  localparam int unsigned IntW       = 32;
  localparam int unsigned TolW       = 23;
  localparam int unsigned IdxOutW    = 10;
  localparam int unsigned CntOutW    = 11;
  localparam int unsigned HitW       = 16;
  localparam int unsigned SumW       = 48;
  localparam int unsigned MaxPeaksDefault = 1024;

  localparam logic [MassW-1:0] UpperMassLimit = 40'd512000000000;
  localparam logic [TolW-1:0]  TolReset       = 23'd42950;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_CLR_TABLE = 2'd1,
    OP_QUERY     = 2'd2,
    OP_CLR_SCORE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ORDER    = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

endpackage

/* rtl/core/pwpm_peak_mem.sv */
// ----------------------------------------------------------------------------
// pwpm_peak_mem: peak table storage
// One synchronous write port and one registered read port per store.
// ----------------------------------------------------------------------------
module pwpm_peak_mem #(
  parameter int unsigned Depth = pwpm_pkg::MaxPeaksDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [pwpm_pkg::MassW-1:0] wmass_i,
  input  logic [pwpm_pkg::IntW-1:0]  wint_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [pwpm_pkg::MassW-1:0] rmass_o,
  output logic [pwpm_pkg::IntW-1:0]  rint_o
);
  import pwpm_pkg::*;

  logic [MassW-1:0] mass_mem [Depth];
  logic [IntW-1:0]  int_mem  [Depth];

  // write and read both stores
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mass_mem[waddr_i] <= wmass_i;
      int_mem[waddr_i]  <= wint_i;
    end
    rmass_o <= mass_mem[raddr_i];
    rint_o  <= int_mem[raddr_i];
  end

endmodule

/* rtl/core/ppm_window_peak_matcher_core.sv */
// ----------------------------------------------------------------------------
// ppm_window_peak_matcher_core: ppm window search over a sorted peak table
// Appends peaks in ascending mass order and answers window queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one transaction with an
//   operation and its operands; each gives exactly one result on the output
//   channel (out_valid_o/out_ready_i). One transaction is worked at a time.
//   A clear or score clear needs no memory access; an append makes one memory
//   read of the last mass for the order check (none into an empty table).
//   A query takes a 2-stage multiply, two binary searches over
//   the table (lower and upper edge, up to log2(depth)+1 probes each, each
//   probe waiting on the registered memory read), then a walk of the window,
//   one registered read per in-window peak, to find the nearest one, plus a
//   step to fold in the score on a hit. All of these reads share the
//   single memory read port.
//   The result sits in an output register; a stalled receiver holds it and
//   the block takes no new transaction until it is taken.
//   Reset empties the table, clears the score accumulators and sets the
//   tolerance to about 10 ppm. Peak memories need no clearing.
//   tol_we_i writes the tolerance register whenever high.
// ----------------------------------------------------------------------------
module ppm_window_peak_matcher_core #(
  parameter int unsigned MaxPeaks = pwpm_pkg::MaxPeaksDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tol_we_i,
  input  logic [pwpm_pkg::TolW-1:0]    tol_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [pwpm_pkg::MassW-1:0]   peak_mass_i,
  input  logic [pwpm_pkg::IntW-1:0]    peak_intensity_i,
  input  logic [pwpm_pkg::MassW-1:0]   expected_mass_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         found_o,
  output logic [pwpm_pkg::IdxOutW-1:0] first_index_o,
  output logic [pwpm_pkg::CntOutW-1:0] window_count_o,
  output logic [pwpm_pkg::IdxOutW-1:0] closest_index_o,
  output logic [pwpm_pkg::IntW-1:0]    closest_intensity_o,
  output logic [pwpm_pkg::HitW-1:0]    matched_count_o,
  output logic [pwpm_pkg::SumW-1:0]    matched_intensity_o,
  output logic [pwpm_pkg::CntOutW-1:0] table_size_o
);
  import pwpm_pkg::*;

  localparam int unsigned AddrW = (MaxPeaks > 1) ? $clog2(MaxPeaks) : 1;
  localparam int unsigned CntW  = $clog2(MaxPeaks + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxPeaks);

  typedef enum logic [3:0] {
    S_IDLE, S_APP_RD, S_APP_CHK, S_MUL1, S_MUL2, S_EDGE,
    S_BS_RD, S_BS_CHK, S_WALK_RD, S_WALK_CHK, S_FIN, S_OUT
  } state_e;

  state_e           state_q;
  logic [1:0]       op_q;
  logic [MassW-1:0] pmass_q, emass_q, hi_q;
  logic [IntW-1:0]  pint_q;
  logic [TolW-1:0]  tol_q;
  logic [CntW-1:0]  entry_q;
  logic [HitW-1:0]  hit_q;
  logic [SumW-1:0]  sum_q;
  // partial products of emass * tol (tol split 23 = 12 + 11)
  logic [MassW+11:0] pp_lo_q;
  logic [MassW+10:0] pp_hi_q;
  // binary search: find first index with mass >= key (upper pass key = hi+1)
  logic             pass_q;        // 0 lower edge, 1 upper edge
  logic [CntW-1:0]  bs_lo_q, bs_hi_q, first_q;
  logic [CntW-1:0]  walk_q, end_q, best_idx_q;
  logic [MassW:0]   key_q;
  logic [MassW-1:0] best_d_q;
  logic             have_q;

  // output register
  logic [1:0]         st_o_q;
  logic               found_q;
  logic [CntW-1:0]    cnt_q;
  logic [IntW-1:0]    cint_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_raddr;
  logic [MassW-1:0] rmass;
  logic [IntW-1:0]  rint;
  logic [CntW-1:0]  bs_mid;

  assign bs_mid = bs_lo_q + ((bs_hi_q - bs_lo_q) >> 1);

  // choose read address per state
  always_comb begin
    case (state_q)
      S_APP_RD:  mem_raddr = AddrW'(entry_q - CntW'(1));
      S_BS_RD:   mem_raddr = AddrW'(bs_mid);
      S_WALK_RD: mem_raddr = AddrW'(walk_q);
      S_FIN:     mem_raddr = AddrW'(best_idx_q);
      default:   mem_raddr = '0;
    endcase
  end

  assign mem_we = (state_q == S_APP_CHK) &&
                  ((entry_q == '0) || (pmass_q >= rmass));

  pwpm_peak_mem #(.Depth(MaxPeaks), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(entry_q)),
    .wmass_i (pmass_q),
    .wint_i  (pint_q),
    .raddr_i (mem_raddr),
    .rmass_o (rmass),
    .rint_o  (rint)
  );

  logic [MassW+23:0] prod;
  logic [MassW-1:0]  shift;
  logic [MassW:0]    hi_sum;
  logic [MassW-1:0]  mass_diff;
  logic [SumW:0]     sum_add;

  assign prod      = (MassW+24)'(pp_lo_q) + ((MassW+24)'(pp_hi_q) << 12);
  assign shift     = MassW'(prod >> 32);
  assign hi_sum    = {1'b0, emass_q} + {1'b0, shift};
  assign mass_diff = (rmass >= emass_q) ? rmass - emass_q : emass_q - rmass;
  assign sum_add   = {1'b0, sum_q} + (SumW+1)'(rint);

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      entry_q <= '0;
      hit_q   <= '0;
      sum_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= operation_i;
            pmass_q <= peak_mass_i;
            pint_q  <= peak_intensity_i;
            emass_q <= expected_mass_i;
            st_o_q  <= ST_OK;
            found_q <= 1'b0;
            first_q <= '0;
            cnt_q   <= '0;
            best_idx_q <= '0;
            cint_q  <= '0;
            case (op_e'(operation_i))
              OP_APPEND: begin
                if (entry_q >= MaxCnt) begin
                  st_o_q  <= ST_FULL;
                  state_q <= S_OUT;
                end else if (entry_q == '0) begin
                  state_q <= S_APP_CHK;
                end else begin
                  state_q <= S_APP_RD;
                end
              end
              OP_CLR_TABLE: begin
                entry_q <= '0;
                state_q <= S_OUT;
              end
              OP_CLR_SCORE: begin
                hit_q   <= '0;
                sum_q   <= '0;
                state_q <= S_OUT;
              end
              default: state_q <= S_MUL1;
            endcase
          end
        end
        S_APP_RD: state_q <= S_APP_CHK;
        S_APP_CHK: begin
          if (mem_we) begin
            entry_q <= entry_q + CntW'(1);
          end else begin
            st_o_q <= ST_ORDER;
          end
          state_q <= S_OUT;
        end
        S_MUL1: begin
          pp_lo_q <= emass_q * tol_q[11:0];
          pp_hi_q <= emass_q * tol_q[22:12];
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          hi_q <= (hi_sum > {1'b0, UpperMassLimit}) ? UpperMassLimit
                                                    : hi_sum[MassW-1:0];
          key_q   <= {1'b0, emass_q - shift};
          pass_q  <= 1'b0;
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          bs_lo_q <= '0;
          bs_hi_q <= entry_q;
          state_q <= (entry_q == '0) ? S_BS_CHK : S_BS_RD;
        end
        S_BS_RD: state_q <= S_BS_CHK;
        S_BS_CHK: begin
          if (bs_lo_q == bs_hi_q) begin
            if (!pass_q) begin
              first_q <= bs_lo_q;
              key_q   <= {1'b0, hi_q} + (MassW+1)'(1);
              pass_q  <= 1'b1;
              state_q <= S_EDGE;
            end else begin
              end_q   <= bs_lo_q;
              walk_q  <= first_q;
              have_q  <= 1'b0;
              state_q <= (bs_lo_q > first_q) ? S_WALK_RD : S_FIN;
            end
          end else begin
            if ({1'b0, rmass} < key_q) begin
              bs_lo_q <= bs_mid + CntW'(1);
            end else begin
              bs_hi_q <= bs_mid;
            end
            state_q <= S_BS_RD;
            if (bs_mid + CntW'(1) == bs_hi_q && {1'b0, rmass} < key_q) begin
              state_q <= S_BS_CHK;
            end
            if (bs_mid == bs_lo_q && !({1'b0, rmass} < key_q)) begin
              state_q <= S_BS_CHK;
            end
          end
        end
        S_WALK_RD: state_q <= S_WALK_CHK;
        S_WALK_CHK: begin
          if (!have_q || mass_diff < best_d_q) begin
            best_d_q   <= mass_diff;
            best_idx_q <= walk_q;
          end
          have_q <= 1'b1;
          walk_q <= walk_q + CntW'(1);
          state_q <= (walk_q + CntW'(1) == end_q) ? S_FIN : S_WALK_RD;
        end
        S_FIN: begin
          // registered intensity read of the nearest peak, used in S_OUT
          state_q <= S_OUT;
          cnt_q <= have_q ? end_q - first_q : '0;
          if (!have_q) begin
            first_q <= '0;
          end
          op_q <= {1'b0, have_q};
        end
        S_OUT: begin
          if (op_q == 2'd1 && state_q == S_OUT && cnt_q != '0 && !found_q) begin
            found_q <= 1'b1;
            cint_q  <= rint;
            if (hit_q != {HitW{1'b1}}) begin
              hit_q <= hit_q + HitW'(1);
            end
            sum_q <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
          end else if (out_ready_i && (found_q || cnt_q == '0 || op_q != 2'd1)) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic out_hold;
  assign out_hold   = (op_q == 2'd1) && (cnt_q != '0) && !found_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT) && !out_hold;

  assign status_o            = st_o_q;
  assign found_o             = found_q;
  assign first_index_o       = IdxOutW'(first_q);
  assign window_count_o      = CntOutW'(cnt_q);
  assign closest_index_o     = IdxOutW'(best_idx_q);
  assign closest_intensity_o = cint_q;
  assign matched_count_o     = hit_q;
  assign matched_intensity_o = sum_q;
  assign table_size_o        = CntOutW'(entry_q);

`ifndef NO_ASSERTIONS
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q <= MaxCnt) else $error("table count above depth");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output open together");
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_q |-> cnt_q != '0) else $error("found with empty window");
  a_bs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BS_CHK |-> bs_lo_q <= bs_hi_q) else $error("search bounds crossed");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: regression for ppm_window_peak_matcher_core
// Drives appends, clears and window queries through the valid/ready input
// channel, predicts every result with a cycle-free model of the peak table
// and score accumulators, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pwpm_pkg::*;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned StallLimit = 20000;
  localparam logic [TolW-1:0] TolMax = 23'd4294967;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [IdxOutW-1:0] first_index;
    logic [CntOutW-1:0] window_count;
    logic [IdxOutW-1:0] closest_index;
    logic [IntW-1:0]    closest_intensity;
    logic [HitW-1:0]    matched_count;
    logic [SumW-1:0]    matched_intensity;
    logic [CntOutW-1:0] table_size;
  } match_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic tol_we_i = 1'b0;
  logic [TolW-1:0] tol_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = OP_CLR_SCORE;
  logic [MassW-1:0] peak_mass_i = '0;
  logic [IntW-1:0] peak_intensity_i = '0;
  logic [MassW-1:0] expected_mass_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic found_o;
  logic [IdxOutW-1:0] first_index_o;
  logic [CntOutW-1:0] window_count_o;
  logic [IdxOutW-1:0] closest_index_o;
  logic [IntW-1:0] closest_intensity_o;
  logic [HitW-1:0] matched_count_o;
  logic [SumW-1:0] matched_intensity_o;
  logic [CntOutW-1:0] table_size_o;

  // Predictor state: peak table, accumulators, tolerance
  logic [MassW-1:0] peak_mass_tbl [TableDepth];
  logic [IntW-1:0]  peak_int_tbl [TableDepth];
  int unsigned      peak_entries;
  logic [HitW-1:0]  hit_total;
  logic [SumW-1:0]  hit_int_sum;
  logic [TolW-1:0]  tol_factor;

  match_result_t pending_results[$];
  bit          idle_en = 1'b1;
  int unsigned hold_off_cycles = 0;
  int unsigned rx_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt = 0, hit_cnt_seen = 0, full_cnt = 0, order_cnt = 0;
  int unsigned empty_cnt = 0, tol_writes = 0;

  ppm_window_peak_matcher_core dut (.*);

  always #4 clk_i = ~clk_i;

  // Compute the result of one transaction and advance the predictor state
  function automatic match_result_t predict_match(logic [1:0] op, logic [MassW-1:0] pm,
                                                  logic [IntW-1:0] pi, logic [MassW-1:0] em);
    match_result_t r;
    logic [63:0] shift, lo, hi, d, best;
    int unsigned cnt;
    logic [SumW:0] sum_next;
    r = '0;
    best = '0;
    cnt = 0;
    case (op)
      OP_APPEND: begin
        if (peak_entries >= TableDepth) begin
          r.status = ST_FULL;
        end else if (peak_entries > 0 && pm < peak_mass_tbl[peak_entries-1]) begin
          r.status = ST_ORDER;
        end else begin
          peak_mass_tbl[peak_entries] = pm;
          peak_int_tbl[peak_entries] = pi;
          peak_entries++;
        end
      end
      OP_CLR_TABLE: peak_entries = 0;
      OP_CLR_SCORE: begin
        hit_total = '0;
        hit_int_sum = '0;
      end
      default: begin
        shift = (64'(em) * 64'(tol_factor)) >> 32;
        lo = 64'(em) - shift;
        hi = 64'(em) + shift;
        if (hi > 64'(UpperMassLimit)) hi = 64'(UpperMassLimit);
        for (int unsigned i = 0; i < peak_entries; i++) begin
          if (64'(peak_mass_tbl[i]) >= lo && 64'(peak_mass_tbl[i]) <= hi) begin
            d = (peak_mass_tbl[i] >= em) ? 64'(peak_mass_tbl[i] - em)
                                         : 64'(em - peak_mass_tbl[i]);
            if (cnt == 0) begin
              r.first_index = IdxOutW'(i);
              r.closest_index = IdxOutW'(i);
              best = d;
            end else if (d < best) begin
              r.closest_index = IdxOutW'(i);
              best = d;
            end
            cnt++;
          end
        end
        r.window_count = CntOutW'(cnt);
        if (cnt > 0) begin
          r.found = 1'b1;
          r.closest_intensity = peak_int_tbl[r.closest_index];
          if (hit_total != '1) hit_total++;
          sum_next = {1'b0, hit_int_sum} + (SumW+1)'(r.closest_intensity);
          hit_int_sum = sum_next[SumW] ? '1 : sum_next[SumW-1:0];
        end
      end
    endcase
    r.matched_count = hit_total;
    r.matched_intensity = hit_int_sum;
    r.table_size = CntOutW'(peak_entries);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  // Check each output transaction, pace the receiver, watch for hangs
  always @(posedge clk_i) begin
    match_result_t exp_r;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit && rst_ni) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("ppm_window_peak_matcher_core regression: fail");
      $finish;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatch_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("status", exp_r.status, status_o);
          check_field("found", exp_r.found, found_o);
          check_field("first_index", exp_r.first_index, first_index_o);
          check_field("window_count", exp_r.window_count, window_count_o);
          check_field("closest_index", exp_r.closest_index, closest_index_o);
          check_field("closest_intensity", exp_r.closest_intensity, closest_intensity_o);
          check_field("matched_count", exp_r.matched_count, matched_count_o);
          check_field("matched_intensity", exp_r.matched_intensity, matched_intensity_o);
          check_field("table_size", exp_r.table_size, table_size_o);
        end
      end
      // Hold off for a requested stretch, else stall in random bursts
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one transaction and record its prediction once accepted
  task automatic send_item(logic [1:0] op, logic [MassW-1:0] pm = '0,
                           logic [IntW-1:0] pi = '0, logic [MassW-1:0] em = '0);
    match_result_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    peak_mass_i <= pm;
    peak_intensity_i <= pi;
    expected_mass_i <= em;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_match(op, pm, pi, em);
    pending_results = {pending_results, r};
    sent_cnt++;
    if (r.found) hit_cnt_seen++;
    if (op == OP_QUERY && !r.found) empty_cnt++;
    if (r.status == ST_FULL) full_cnt++;
    if (r.status == ST_ORDER) order_cnt++;
  endtask

  // Drop valid and wait until every outstanding result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TolW-1:0] value);
    drain_results();
    tol_we_i <= 1'b1;
    tol_wdata_i <= value;
    @(posedge clk_i);
    tol_we_i <= 1'b0;
    tol_factor = value;
    tol_writes++;
  endtask

  function automatic logic [MassW-1:0] rand_mass();
    return MassW'({$urandom(), $urandom()});
  endfunction

  // Query near a stored peak, spread over a bit more than the window
  task automatic query_near_peak();
    logic [63:0] m, w, span;
    longint signed em;
    m = peak_mass_tbl[$urandom_range(0, peak_entries - 1)];
    w = (m * 64'(tol_factor)) >> 32;
    span = 2 * w + 3;
    em = longint'(m) - longint'(w + 1) + longint'({$urandom(), $urandom()} % span);
    if (em < 0) em = 0;
    if (em > longint'(64'hFF_FFFF_FFFF)) em = longint'(64'hFF_FFFF_FFFF);
    send_item(OP_QUERY, '0, '0, MassW'(em));
  endtask

  task automatic test_empty_and_clears();
    send_item(OP_QUERY, '0, '0, '0);
    send_item(OP_QUERY, '0, '0, '1);
    send_item(OP_CLR_TABLE);
    send_item(OP_CLR_SCORE);
  endtask

  task automatic test_directed_edges();
    // Zero mass, equal mass, an out-of-order peak, extreme intensities
    send_item(OP_APPEND, '0, '1);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_APPEND, 40'd1000, 32'h8000_0001);
    send_item(OP_APPEND, 40'd999, 32'h1);
    send_item(OP_QUERY, '0, '0, '0);
    // Exact window: every copy of a duplicated mass counts
    write_tolerance('0);
    send_item(OP_APPEND, 40'd1000, 32'h7fff_fffe);
    send_item(OP_QUERY, '0, '0, 40'd1000);
    send_item(OP_QUERY, '0, '0, 40'd1001);
    // Peaks around the upper mass limit, queries clamp the upper edge
    write_tolerance(TolMax);
    send_item(OP_APPEND, UpperMassLimit - 40'd5, 32'd11);
    send_item(OP_APPEND, UpperMassLimit, 32'd22);
    send_item(OP_APPEND, UpperMassLimit + 40'd1, 32'd33);
    send_item(OP_APPEND, '1, 32'd44);
    send_item(OP_QUERY, '0, '0, UpperMassLimit - 40'd2);
    send_item(OP_QUERY, '0, '0, UpperMassLimit + 40'd1);
    send_item(OP_QUERY, '0, '0, 40'd600000000000);
    send_item(OP_QUERY, '0, '0, '1);
    send_item(OP_CLR_SCORE);
    send_item(OP_QUERY, '0, '0, 40'd1000);
    write_tolerance(TolReset);
    send_item(OP_CLR_TABLE);
  endtask

  task automatic test_full_table();
    logic [MassW-1:0] m;
    send_item(OP_CLR_TABLE);
    m = 40'd400000000000;
    for (int i = 0; i < TableDepth; i++) begin
      send_item(OP_APPEND, m, $urandom());
      m += MassW'($urandom_range(0, 8));
    end
    send_item(OP_APPEND, m, 32'd5);
    send_item(OP_APPEND, '1, 32'd6);
    write_tolerance(TolMax);
    send_item(OP_QUERY, '0, '0, 40'd400000004000);
    write_tolerance(TolReset);
    for (int i = 0; i < 6; i++) query_near_peak();
    send_item(OP_CLR_TABLE);
  endtask

  // Mostly well-formed tables with nearby queries, plus noise
  task automatic test_random_sets(int unsigned n_items);
    logic [MassW-1:0] m;
    int unsigned n_peaks, target, scale;
    target = sent_cnt + n_items;
    while (sent_cnt < target) begin
      case ($urandom_range(0, 5))
        0: write_tolerance('0);
        1: write_tolerance(TolMax);
        2: write_tolerance(TolW'($urandom_range(0, TolMax)));
        default: ;
      endcase
      send_item(OP_CLR_TABLE);
      if ($urandom_range(0, 3) == 0) send_item(OP_CLR_SCORE);
      scale = $urandom_range(0, 2);
      m = (scale == 0) ? MassW'($urandom_range(0, 4096)) :
          (scale == 1) ? MassW'({$urandom_range(0, 600000), 10'd0}) : rand_mass();
      n_peaks = $urandom_range(2, 24);
      for (int i = 0; i < n_peaks; i++) begin
        if ($urandom_range(0, 9) == 0 && m > 0) begin
          send_item(OP_APPEND, m - MassW'($urandom_range(1, 50)), $urandom());
        end else begin
          if ($urandom_range(0, 4) != 0)
            m = m + ((scale == 2) ? MassW'($urandom()) : MassW'($urandom_range(0, 2000)));
          send_item(OP_APPEND, m, $urandom());
        end
      end
      for (int i = 0; i < $urandom_range(4, 16); i++) begin
        case ($urandom_range(0, 9))
          0: send_item(OP_QUERY, '0, '0, rand_mass());
          1: send_item(2'($urandom_range(0, 3)), rand_mass(), $urandom(), rand_mass());
          default: if (peak_entries > 0) query_near_peak();
                   else send_item(OP_QUERY, '0, '0, rand_mass());
        endcase
      end
    end
  endtask

  task automatic test_pressure();
    drain_results();
    hold_off_cycles = 300;
    for (int i = 0; i < 8; i++) send_item(OP_APPEND, 40'd5000 + 40'(i), $urandom());
    send_item(OP_QUERY, '0, '0, 40'd5003);
    drain_results();
    for (int i = 0; i < 6; i++) query_near_peak();
  endtask

  initial begin
    peak_entries = 0;
    hit_total = '0;
    hit_int_sum = '0;
    tol_factor = TolReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_empty_and_clears();
    test_directed_edges();
    test_full_table();
    test_pressure();
    test_random_sets(100);
    // Last stretch runs with no idling on either side
    drain_results();
    idle_en = 1'b0;
    test_random_sets(60);
    drain_results();
    repeat (50) @(posedge clk_i);
    $display("covered %0d transactions: %0d hits, %0d empty windows, %0d full, %0d %s",
             sent_cnt, hit_cnt_seen, empty_cnt, full_cnt, order_cnt, "order rejects");
    $display("tolerance written %0d times incl. zero and maximum; %0d results left",
             tol_writes, pending_results.size());
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("ppm_window_peak_matcher_core regression: pass");
    end else begin
      $display("ppm_window_peak_matcher_core regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pwpm_pkg.sv
rtl/core/pwpm_peak_mem.sv
rtl/core/ppm_window_peak_matcher_core.sv
verif/testbench.sv
